FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/wsenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsenc_pkg;

  localparam logic       OP_HEADER  = 1'b0;
  localparam logic       OP_PAYLOAD = 1'b1;

  localparam logic [7:0]  FIN_BIT        = 8'h80;
  localparam logic [7:0]  MASK_BIT       = 8'h80;
  localparam logic [15:0] LEN7_MAX       = 16'd125;
  localparam logic [6:0]  LEN_CODE16     = 7'd126;
  localparam logic [31:0] MASK_KEY_RESET = 32'h1234_5678;

  localparam int          STEP_W         = 3;
  localparam logic [2:0]  LAST_STEP_SHORT = 3'd5;
  localparam logic [2:0]  LAST_STEP_EXT   = 3'd7;

  localparam int          PADDR_W      = 3;
  localparam logic        REG_MASK_KEY = 1'b0;
  localparam logic [2:0]  ADDR_MASK_KEY = 3'd0;

  typedef struct packed {
    logic        op;
    logic [3:0]  opcode;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
  } out_t;

  // One queued command: a whole header, or one masked payload byte.
  typedef struct packed {
    logic        is_hdr;
    logic [3:0]  opcode;
    logic [15:0] length;
    logic [31:0] key;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      2'd3:    b = key[7:0];
      default: b = key[31:24];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/websocket_masked_frame_encoder_unit.sv
// Masked client-side WebSocket frame encoder, one frame byte per output word.
// Input queue side: push an item while full is low. op 0 is a frame header
// (opcode, payload_length up to 65535); op 1 is one payload byte. Payload
// bytes that arrive with no frame open are dropped without a result.
// Output queue side: result holds the oldest byte while empty is low; pop
// takes it. frame_last marks the final byte of each frame.
// With the back idle, an accepted item goes into the command queue and its
// first byte then into the result register.
// Throughput: one output word per cycle while a command is queued and pop
// keeps up. A payload item yields one byte; a header yields six bytes (eight
// with the 16-bit length form), walked out by the sequencer at the queue head.
// The command queue (CMD_DEPTH entries) lets input keep arriving while the
// sequencer works, and full rises only when it fills.
// When pop stays low the output word holds, the sequencer stops, and the
// queue fills up to full. Reset clears frame state and both queues and
// loads the mask key with 0x12345678. The APB port writes the key at any
// address 0 to 3, read at 0; write it only while no frame is in progress.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module websocket_masked_frame_encoder_unit import wsenc_pkg::*; #(
  parameter int CMD_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire in_t                item,
  output logic                    empty,
  input  wire logic               pop,
  output out_t                    result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [31:0] mask_key;
  logic        cmd_push, cmd_pop, cmd_empty;
  cmd_t        cmd_in, cmd_head;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MASK_KEY) ? mask_key : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_key <= MASK_KEY_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[PADDR_W-1:2] == REG_MASK_KEY)) begin
      mask_key <= pwdata;
    end
  end

  wsenc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .mask_key  (mask_key),
    .cmdq_full (full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  wsenc_cmdq #(
    .DEPTH (CMD_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_in),
    .rd    (cmd_pop),
    .rdata (cmd_head),
    .full  (full),
    .empty (cmd_empty)
  );

  wsenc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (cmd_head),
    .head_valid (!cmd_empty),
    .head_pop   (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  `ASSERT_NOW(a_q_sane, clk, rst, full, !cmd_empty, "command queue full and empty at once")
  `ASSERT_NEXT(a_fill, clk, rst, !cmd_empty && empty, !empty, "pending command left output empty")
  `ASSERT_NEXT(a_flow, clk, rst, !cmd_empty && pop && !empty, !empty, "output bubble with command pending")
  `ASSERT_NOW(a_pop_src, clk, rst, cmd_pop, !cmd_empty, "command popped from empty queue")

endmodule

`default_nettype wire

FILE: hdl/wsenc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wsenc_front import wsenc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire in_t         item,
  input  wire logic [31:0] mask_key,
  input  wire logic        cmdq_full,
  output logic             cmd_push,
  output cmd_t             cmd
);

  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [1:0]  mask_position, mask_position_next;
  logic        frame_open, frame_open_next;
  logic        accept;
  logic [15:0] rem_dec;

  assign accept  = push && !cmdq_full;
  assign rem_dec = bytes_remaining - 16'd1;

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    mask_position_next   = mask_position;
    frame_open_next      = frame_open;
    cmd_push             = 1'b0;
    cmd.is_hdr           = (item.op == OP_HEADER);
    cmd.opcode           = item.opcode;
    cmd.length           = item.payload_length;
    cmd.key              = mask_key;
    cmd.data             = item.data_byte ^ key_byte(mask_key, mask_position);
    cmd.last             = (rem_dec == 16'd0);
    if (accept) begin
      if (item.op == OP_HEADER) begin
        cmd_push             = 1'b1;
        bytes_remaining_next = item.payload_length;
        mask_position_next   = 2'd0;
        frame_open_next      = (item.payload_length != 16'd0);
      end else if (frame_open) begin
        // payload with no open frame is dropped
        cmd_push             = 1'b1;
        bytes_remaining_next = rem_dec;
        mask_position_next   = mask_position + 2'd1;
        frame_open_next      = (rem_dec != 16'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 16'd0;
      mask_position   <= 2'd0;
      frame_open      <= 1'b0;
    end else begin
      bytes_remaining <= bytes_remaining_next;
      mask_position   <= mask_position_next;
      frame_open      <= frame_open_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wsenc_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none

module wsenc_cmdq import wsenc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wdata,
  input  wire logic rd,
  output cmd_t      rdata,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wsenc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wsenc_back import wsenc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t head,
  input  wire logic head_valid,
  output logic      head_pop,
  input  wire logic pop,
  output logic      empty,
  output out_t      result
);

  logic [STEP_W-1:0] step;
  logic              out_valid;
  logic              advance;
  logic              ext;
  logic [STEP_W-1:0] last_step;
  logic [1:0]        key_idx;
  logic [7:0]        key_b;
  out_t              word;

  assign ext       = head.length > LEN7_MAX;
  assign last_step = !head.is_hdr ? '0 : (ext ? LAST_STEP_EXT : LAST_STEP_SHORT);
  assign key_idx   = ext ? 2'(step - 3'd4) : 2'(step - 3'd2);
  assign key_b     = key_byte(head.key, key_idx);
  assign advance   = head_valid && (!out_valid || pop);
  assign head_pop  = advance && (step == last_step);
  assign empty     = !out_valid;

  always_comb begin
    word.out_byte   = head.data;
    word.frame_last = head.last;
    if (head.is_hdr) begin
      word.frame_last = (head.length == 16'd0) && (step == last_step);
      case (step)
        3'd0:    word.out_byte = FIN_BIT | {4'd0, head.opcode};
        3'd1:    word.out_byte = MASK_BIT | (ext ? {1'b0, LEN_CODE16} : {1'b0, head.length[6:0]});
        3'd2:    word.out_byte = ext ? head.length[15:8] : key_b;
        3'd3:    word.out_byte = ext ? head.length[7:0] : key_b;
        default: word.out_byte = key_b;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        // hold the command at the queue head until its last byte goes out
        step      <= (step == last_step) ? '0 : step + 3'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wsenc_pkg::*;

  localparam int TIMEOUT_CYCLES = 300000;
  localparam int DRAIN_CYCLES   = 20;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_t item = '0;
  logic empty;
  logic pop = 1'b0;
  out_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  websocket_masked_frame_encoder_unit u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // encoder shadow state
  logic [31:0] key_cfg = MASK_KEY_RESET;
  logic [15:0] left_bytes = '0;
  logic [1:0] key_pos = '0;
  logic frame_on = 1'b0;

  in_t pending_items[$];
  out_t frame_bytes_q[$];

  int cyc = 0;
  int errors = 0;
  int items_accepted = 0;
  int headers_seen = 0;
  int ext_headers = 0;
  int dropped_payloads = 0;
  int words_checked = 0;
  int random_items = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > TIMEOUT_CYCLES) begin
      $display("tb_top: timeout after %0d cycles", cyc);
      $display("tb_top: errors");
      $finish;
    end
  end

  // idle about 8% of cycles, except in a quiet window mid-run
  function automatic bit idle_now();
    return (items_accepted < 250 || items_accepted > 330) && ($urandom_range(99) < 8);
  endfunction

  task automatic add_item(input in_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    errors++;
    if (errors <= 10)
      $display("tb_top: %s mismatch at cycle %0d: expected %0h got %0h",
               what, cyc, want_v, got_v);
  endtask

  task automatic emit_byte(input logic [7:0] b, input logic last);
    out_t w;
    w.out_byte = b;
    w.frame_last = last;
    frame_bytes_q.insert(frame_bytes_q.size(), w);
  endtask

  task automatic encode_item(input in_t it);
    logic [15:0] len;
    len = it.payload_length;
    if (it.op == OP_HEADER) begin
      headers_seen++;
      emit_byte(FIN_BIT | {4'h0, it.opcode}, 1'b0);
      if (len <= LEN7_MAX) begin
        emit_byte(MASK_BIT | {1'b0, len[6:0]}, 1'b0);
      end else begin
        ext_headers++;
        emit_byte(MASK_BIT | {1'b0, LEN_CODE16}, 1'b0);
        emit_byte(len[15:8], 1'b0);
        emit_byte(len[7:0], 1'b0);
      end
      for (int k = 0; k < 4; k++)
        emit_byte(key_cfg[31 - 8*k -: 8], (len == 16'd0) && (k == 3));
      left_bytes = len;
      key_pos = 2'd0;
      frame_on = (len != 16'd0);
    end else if (frame_on) begin
      left_bytes = left_bytes - 16'd1;
      emit_byte(it.data_byte ^ key_cfg[31 - 8*int'(key_pos) -: 8], left_bytes == 16'd0);
      key_pos = key_pos + 2'd1;
      if (left_bytes == 16'd0)
        frame_on = 1'b0;
    end else begin
      dropped_payloads++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        encode_item(item);
        items_accepted++;
      end
      if (!push || !full) begin
        if (pending_items.size() != 0 && !idle_now()) begin
          item <= pending_items.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // one long hold-off so the input side backs up
  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && words_checked >= 150) begin
        hold_left <= 500;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      if (pop && !empty) begin
        words_checked++;
        if (frame_bytes_q.size() == 0) begin
          report_mismatch("unexpected word", 32'h0, {23'h0, result});
        end else begin
          want = frame_bytes_q.pop_front();
          if (result.out_byte !== want.out_byte)
            report_mismatch("out_byte", want.out_byte, result.out_byte);
          if (result.frame_last !== want.frame_last)
            report_mismatch("frame_last", want.frame_last, result.frame_last);
        end
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
      end else begin
        pop <= !idle_now();
      end
    end
  end

  function automatic in_t mk(input logic op, input logic [3:0] opc,
                             input logic [15:0] len, input logic [7:0] d);
    in_t t;
    t.op = op;
    t.opcode = opc;
    t.payload_length = len;
    t.data_byte = d;
    return t;
  endfunction

  function automatic in_t rand_payload();
    return mk(OP_PAYLOAD, 4'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  task automatic write_key(input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MASK_KEY;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    key_cfg = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait until every word is in and out, then let the pipe settle
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || push || frame_bytes_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_random_frame(output int counted);
    int r, len, n;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(12);
    else if (r < 85) len = $urandom_range(65535);
    else if (r < 89) len = $urandom_range(131, 126);
    else len = $urandom_range(125, 1);
    add_item(mk(OP_HEADER, 4'($urandom), 16'(len), 8'($urandom)));
    if (r < 70 || (r >= 85 && r < 89)) n = len;
    else if (r < 85) n = (len < 6) ? $urandom_range(len) : $urandom_range(6);
    else n = (len < 8) ? len : $urandom_range(8);
    for (int k = 0; k < n; k++)
      add_item(rand_payload());
    counted = 1 + n;
    // stray byte after a closed frame: dropped by the block
    if (n == len && $urandom_range(99) < 15)
      add_item(rand_payload());
  endtask

  task automatic queue_random(input int target);
    int got, n;
    got = 0;
    while (got < target) begin
      add_random_frame(n);
      got += n;
    end
    random_items += got;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset key
    add_item(mk(OP_HEADER, 4'h0, 16'd0, 8'hFF));       // empty frame
    add_item(mk(OP_PAYLOAD, 4'h0, 16'd0, 8'hAA));      // no frame open
    add_item(mk(OP_HEADER, 4'hF, 16'd1, 8'h55));
    add_item(mk(OP_PAYLOAD, 4'hF, 16'hFFFF, 8'hFF));
    add_item(mk(OP_HEADER, 4'h1, 16'd125, 8'h00));
    add_item(mk(OP_PAYLOAD, 4'h3, 16'd7, 8'h00));
    add_item(mk(OP_HEADER, 4'h2, 16'd126, 8'h11));     // abandons open frame
    add_item(mk(OP_PAYLOAD, 4'h0, 16'd0, 8'h5A));
    add_item(mk(OP_PAYLOAD, 4'h0, 16'd0, 8'hC3));
    add_item(mk(OP_HEADER, 4'h8, 16'hFFFF, 8'h00));
    add_item(mk(OP_PAYLOAD, 4'h0, 16'd0, 8'h80));
    add_item(mk(OP_HEADER, 4'h9, 16'd3, 8'h00));
    add_item(mk(OP_PAYLOAD, 4'h0, 16'd0, 8'h01));
    add_item(mk(OP_PAYLOAD, 4'h0, 16'd0, 8'h7F));
    add_item(mk(OP_PAYLOAD, 4'h0, 16'd0, 8'hFE));
    add_item(mk(OP_PAYLOAD, 4'h0, 16'd0, 8'h33));      // after close
    add_item(mk(OP_HEADER, 4'hA, 16'd127, 8'h00));
    add_item(mk(OP_HEADER, 4'h7, 16'd5, 8'h00));
    add_item(mk(OP_PAYLOAD, 4'h0, 16'd0, 8'h12));
    add_item(mk(OP_PAYLOAD, 4'h0, 16'd0, 8'hED));
    drain();

    // key changes while the last frame is still open
    write_key(32'h0000_0000);
    for (int k = 0; k < 3; k++)
      add_item(rand_payload());
    queue_random(105);
    drain();

    write_key(32'hFFFF_FFFF);
    queue_random(55);
    drain();                       // sender pause until all words are back
    queue_random(55);
    drain();

    write_key($urandom);
    queue_random(100);
    drain();

    write_key(MASK_KEY_RESET ^ $urandom);
    queue_random(100);
    drain();

    if (frame_bytes_q.size() != 0)
      report_mismatch("leftover words", 32'h0, frame_bytes_q.size());
    $display("tb_top: %0d items (%0d random), %0d headers (%0d with 16-bit length),",
             items_accepted, random_items, headers_seen, ext_headers);
    $display("tb_top: %0d stray payload bytes dropped, %0d frame bytes checked, %0d bad",
             dropped_payloads, words_checked, errors);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/wsenc_pkg.sv
hdl/wsenc_front.sv
hdl/wsenc_cmdq.sv
hdl/wsenc_back.sv
hdl/websocket_masked_frame_encoder_unit.sv
tb/tb_top.sv
